// ----- rtl/dtds_pkg.sv -----
// Shared types, widths and constants for the delta-T differential switch.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package dtds_pkg;

   // Field widths
   localparam int TEMP_W       = 16;
   localparam int DELTA_W      = 16;
   localparam int THR_W        = 8;
   localparam int HYS_W        = 5;
   localparam int OPT_W        = 5;
   localparam int WAIT_UNITS_W = 8;
   localparam int INTERVAL_W   = 16;
   localparam int OWL_W        = 21;
   localparam int COUNT_W      = 8;
   localparam int CMD_W        = 8;
   localparam int DISP_W       = 8;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 3;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_FORCE_OFF  = 8'd203;
   localparam logic [CMD_W-1:0] CMD_FORCE_ON   = 8'd205;
   localparam logic [CMD_W-1:0] CMD_MANUAL_MAX = 8'd200;
   localparam logic [CMD_W-1:0] CMD_MANUAL_OFF = 8'd0;

   // Divide-by-ten reciprocal: (x * 0xCCCD) >> 19 is exact for 16-bit x
   localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;

   localparam int                 WAIT_STEP   = 5000;
   localparam logic [DISP_W-1:0]  DISPLAY_OUT = 8'd255;

   // Option bit positions
   localparam int OPT_NO_DELAY_MAX = 0;
   localparam int OPT_NO_DELAY_MIN = 1;
   localparam int OPT_NO_HYS_OFF   = 2;
   localparam int OPT_NOT_INVERTED = 3;
   localparam int OPT_ERROR_OFF    = 4;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_MAX_FIRST   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MIN_SECOND  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OPTIONS     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LOCKED      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CHANGE_WAIT = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_INTERVAL    = 3'd7;

   // Register reset values
   localparam logic signed [TEMP_W-1:0] MAX_FIRST_RESET  = 16'sh7FFF;
   localparam logic signed [TEMP_W-1:0] MIN_SECOND_RESET = 16'sh8000;
   localparam logic [THR_W-1:0]         THRESHOLD_RESET  = 8'd40;
   localparam logic [HYS_W-1:0]         HYSTERESIS_RESET = 5'd6;
   localparam logic [OPT_W-1:0]         OPTIONS_RESET    = 5'd31;
   localparam logic [WAIT_UNITS_W-1:0]  CHANGE_WAIT_RESET = 8'd0;
   localparam logic [INTERVAL_W-1:0]    INTERVAL_RESET   = 16'd3000;

   // Output wait after reset: four calculation intervals
   localparam logic [OWL_W-1:0] OWL_RESET = OWL_W'(4 * 3000);
   localparam logic signed [DELTA_W-1:0] DELTA_RESET = 16'sd255;

   // Special temperatures
   localparam logic signed [TEMP_W-1:0] NEVER_SEEN_TEMP_DEF   = -16'sd27315;
   localparam logic signed [TEMP_W-1:0] SENSOR_FAULT_TEMP_DEF = -16'sd27314;

   typedef struct packed {
      logic signed [TEMP_W-1:0] max_first_temp;
      logic signed [TEMP_W-1:0] min_second_temp;
      logic [THR_W-1:0]         delta_on_threshold;
      logic [HYS_W-1:0]         delta_hysteresis;
      logic [OPT_W-1:0]         option_bits;
      logic                     channel_locked;
      logic [WAIT_UNITS_W-1:0]  change_wait_units;
      logic [INTERVAL_W-1:0]    calc_interval_ticks;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] first_temp;
      logic signed [TEMP_W-1:0] second_temp;
      logic                     command_valid;
      logic [CMD_W-1:0]         command_byte;
      logic                     inhibit;
   } tick_type;

   typedef struct packed {
      tick_type                  tick;
      logic signed [DELTA_W-1:0] delta;
   } delta_item_type;

endpackage

// ----- rtl/delta_t_differential_switch.sv -----
// Pipeline: input register, delta stage with one divide-by-ten multiplier,
// decision logic into the result register. Accepts one tick transaction per
// cycle while the result channel is not stalled by rsp_ready.
// Reset (synchronous, active high): registers to defaults, output off,
// change count zero, first output commit held for 12000 ticks.
`timescale 1ns / 1ps

module delta_t_differential_switch #(
   parameter logic signed [dtds_pkg::TEMP_W-1:0] NEVER_SEEN_TEMP =
      dtds_pkg::NEVER_SEEN_TEMP_DEF,
   parameter logic signed [dtds_pkg::TEMP_W-1:0] SENSOR_FAULT_TEMP =
      dtds_pkg::SENSOR_FAULT_TEMP_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Tick channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dtds_pkg::TEMP_W-1:0]  req_first_temp,
   input  logic signed [dtds_pkg::TEMP_W-1:0]  req_second_temp,
   input  logic                                req_command_valid,
   input  logic [dtds_pkg::CMD_W-1:0]          req_command_byte,
   input  logic                                req_inhibit,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pin_level,
   output logic                                rsp_output_on,
   output logic                                rsp_mode_active,
   output logic [dtds_pkg::DISP_W-1:0]         rsp_delta_display,
   output logic                                rsp_delta_in_range,
   output logic                                rsp_state_changed,
   output logic [dtds_pkg::COUNT_W-1:0]        rsp_press_count,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dtds_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dtds_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dtds_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   dtds_pkg::cfg_type          cfg;
   dtds_pkg::tick_type         tick;
   dtds_pkg::delta_item_type   d_item;
   logic                       d_valid;
   logic                       d_ready;

   assign tick.first_temp    = req_first_temp;
   assign tick.second_temp   = req_second_temp;
   assign tick.command_valid = req_command_valid;
   assign tick.command_byte  = req_command_byte;
   assign tick.inhibit       = req_inhibit;

   dtds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dtds_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_tick   (tick),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_item  (d_item)
   );

   dtds_core #(
      .NEVER_SEEN_TEMP   (NEVER_SEEN_TEMP),
      .SENSOR_FAULT_TEMP (SENSOR_FAULT_TEMP)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .in_valid           (d_valid),
      .in_ready           (d_ready),
      .in_item            (d_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pin_level      (rsp_pin_level),
      .rsp_output_on      (rsp_output_on),
      .rsp_mode_active    (rsp_mode_active),
      .rsp_delta_display  (rsp_delta_display),
      .rsp_delta_in_range (rsp_delta_in_range),
      .rsp_state_changed  (rsp_state_changed),
      .rsp_press_count    (rsp_press_count)
   );

endmodule

// ----- rtl/dtds_csr.sv -----
// APB-style configuration registers of the delta-T switch.
// Depends on dtds_pkg.
`timescale 1ns / 1ps

module dtds_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dtds_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dtds_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dtds_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output dtds_pkg::cfg_type                   cfg
);

   dtds_pkg::cfg_type                 cfg_ff;
   logic [dtds_pkg::REG_IDX_W-1:0]    idx;
   logic                              wr_en;

   assign idx    = paddr[dtds_pkg::CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_first_temp      <= dtds_pkg::MAX_FIRST_RESET;
         cfg_ff.min_second_temp     <= dtds_pkg::MIN_SECOND_RESET;
         cfg_ff.delta_on_threshold  <= dtds_pkg::THRESHOLD_RESET;
         cfg_ff.delta_hysteresis    <= dtds_pkg::HYSTERESIS_RESET;
         cfg_ff.option_bits         <= dtds_pkg::OPTIONS_RESET;
         cfg_ff.channel_locked      <= 1'b0;
         cfg_ff.change_wait_units   <= dtds_pkg::CHANGE_WAIT_RESET;
         cfg_ff.calc_interval_ticks <= dtds_pkg::INTERVAL_RESET;
      end else if (wr_en) begin
         unique case (idx)
            dtds_pkg::REG_MAX_FIRST:
               cfg_ff.max_first_temp <= pwdata[dtds_pkg::TEMP_W-1:0];
            dtds_pkg::REG_MIN_SECOND:
               cfg_ff.min_second_temp <= pwdata[dtds_pkg::TEMP_W-1:0];
            dtds_pkg::REG_THRESHOLD:
               cfg_ff.delta_on_threshold <= pwdata[dtds_pkg::THR_W-1:0];
            dtds_pkg::REG_HYSTERESIS:
               cfg_ff.delta_hysteresis <= pwdata[dtds_pkg::HYS_W-1:0];
            dtds_pkg::REG_OPTIONS:
               cfg_ff.option_bits <= pwdata[dtds_pkg::OPT_W-1:0];
            dtds_pkg::REG_LOCKED:
               cfg_ff.channel_locked <= pwdata[0];
            dtds_pkg::REG_CHANGE_WAIT:
               cfg_ff.change_wait_units <= pwdata[dtds_pkg::WAIT_UNITS_W-1:0];
            dtds_pkg::REG_INTERVAL:
               cfg_ff.calc_interval_ticks <= pwdata[dtds_pkg::INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back, zero-extended
   always_comb begin
      unique case (idx)
         dtds_pkg::REG_MAX_FIRST:
            prdata = dtds_pkg::CSR_DATA_W'(unsigned'(cfg_ff.max_first_temp));
         dtds_pkg::REG_MIN_SECOND:
            prdata = dtds_pkg::CSR_DATA_W'(unsigned'(cfg_ff.min_second_temp));
         dtds_pkg::REG_THRESHOLD:
            prdata = dtds_pkg::CSR_DATA_W'(cfg_ff.delta_on_threshold);
         dtds_pkg::REG_HYSTERESIS:
            prdata = dtds_pkg::CSR_DATA_W'(cfg_ff.delta_hysteresis);
         dtds_pkg::REG_OPTIONS:
            prdata = dtds_pkg::CSR_DATA_W'(cfg_ff.option_bits);
         dtds_pkg::REG_LOCKED:
            prdata = dtds_pkg::CSR_DATA_W'(cfg_ff.channel_locked);
         dtds_pkg::REG_CHANGE_WAIT:
            prdata = dtds_pkg::CSR_DATA_W'(cfg_ff.change_wait_units);
         dtds_pkg::REG_INTERVAL:
            prdata = dtds_pkg::CSR_DATA_W'(cfg_ff.calc_interval_ticks);
         default:
            prdata = '0;
      endcase
   end

endmodule

// ----- rtl/dtds_delta.sv -----
// Input register and delta stage: registers the tick transaction, then
// computes (second - first) / 10 by reciprocal multiply. Depends on dtds_pkg.
`timescale 1ns / 1ps

module dtds_delta (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  dtds_pkg::tick_type         in_tick,
   output logic                       out_valid,
   input  logic                       out_ready,
   output dtds_pkg::delta_item_type   out_item
);

   logic                       a_valid_ff;
   dtds_pkg::tick_type         a_tick_ff;
   logic                       b_valid_ff;
   dtds_pkg::delta_item_type   b_item_ff;

   logic                       b_free;
   logic                       move_ab;
   logic signed [16:0]         diff;
   logic [16:0]                mag;
   logic [31:0]                prod;
   logic [12:0]                quot;
   logic signed [dtds_pkg::DELTA_W-1:0] delta_in;

   assign b_free    = ~b_valid_ff | out_ready;
   assign move_ab   = a_valid_ff & b_free;
   assign in_ready  = ~a_valid_ff | b_free;
   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

   // Truncating divide by ten on the magnitude, sign restored afterwards
   always_comb begin
      diff = {a_tick_ff.second_temp[15], a_tick_ff.second_temp}
           - {a_tick_ff.first_temp[15], a_tick_ff.first_temp};
      mag  = diff[16] ? 17'(-diff) : 17'(diff);
      prod = mag[15:0] * dtds_pkg::DIV10_RECIP;
      quot = prod[31:dtds_pkg::DIV10_SHIFT];
      delta_in = diff[16] ? -signed'({3'b000, quot}) : signed'({3'b000, quot});
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         a_tick_ff <= in_tick;
      end
      if (move_ab) begin
         b_item_ff.tick  <= a_tick_ff;
         b_item_ff.delta <= delta_in;
      end
   end

endmodule

// ----- rtl/dtds_core.sv -----
// Switching decision, wait counters and result register of the delta-T
// switch. Depends on dtds_pkg.
`timescale 1ns / 1ps

module dtds_core #(
   parameter logic signed [dtds_pkg::TEMP_W-1:0] NEVER_SEEN_TEMP =
      dtds_pkg::NEVER_SEEN_TEMP_DEF,
   parameter logic signed [dtds_pkg::TEMP_W-1:0] SENSOR_FAULT_TEMP =
      dtds_pkg::SENSOR_FAULT_TEMP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dtds_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  dtds_pkg::delta_item_type          in_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pin_level,
   output logic                              rsp_output_on,
   output logic                              rsp_mode_active,
   output logic [dtds_pkg::DISP_W-1:0]       rsp_delta_display,
   output logic                              rsp_delta_in_range,
   output logic                              rsp_state_changed,
   output logic [dtds_pkg::COUNT_W-1:0]      rsp_press_count
);

   // State
   logic                                   cur_ff, cur_in;
   logic                                   next_ff, next_in;
   logic signed [dtds_pkg::DELTA_W-1:0]    delta_ff, delta_in;
   logic                                   init_ff, init_in;
   logic                                   force_ff, force_in;
   logic                                   mode_ff, mode_in;
   logic [dtds_pkg::OWL_W-1:0]             owl_ff, owl_in;
   logic [dtds_pkg::INTERVAL_W-1:0]        cwl_ff, cwl_in;
   logic [dtds_pkg::COUNT_W-1:0]           count_ff, count_in;
   logic                                   changed_in;

   // Result register
   logic                                   rsp_valid_ff;
   logic                                   pin_ff, on_ff, mode_out_ff;
   logic [dtds_pkg::DISP_W-1:0]            disp_ff, disp_in;
   logic                                   range_ff, range_in;
   logic                                   changed_ff;
   logic [dtds_pkg::COUNT_W-1:0]           count_out_ff;

   logic                                   adv;
   logic                                   err_on;
   logic signed [dtds_pkg::TEMP_W-1:0]     t1, t2;
   logic signed [16:0]                     d17, thr17, hys17, hoff17, hys10;
   logic signed [16:0]                     dmax, dmin;
   logic [8:0]                             hys_x10;
   logic [dtds_pkg::OWL_W-1:0]             owl_units, owl_reload;
   logic [dtds_pkg::CMD_W-1:0]             cmd;

   assign in_ready = ~rsp_valid_ff | rsp_ready;
   assign adv      = in_valid & in_ready;
   assign err_on   = ~cfg.option_bits[dtds_pkg::OPT_ERROR_OFF];

   assign t1  = in_item.tick.first_temp;
   assign t2  = in_item.tick.second_temp;
   assign cmd = in_item.tick.command_byte;

   // Comparison operands (17-bit signed) and the output wait reload value
   always_comb begin
      hys_x10 = {1'b0, cfg.delta_hysteresis, 3'b000}
              + {3'b000, cfg.delta_hysteresis, 1'b0};
      d17     = {in_item.delta[15], in_item.delta};
      thr17   = signed'({9'd0, cfg.delta_on_threshold});
      hys17   = signed'({12'd0, cfg.delta_hysteresis});
      hoff17  = cfg.option_bits[dtds_pkg::OPT_NO_HYS_OFF] ? 17'sd0 : hys17;
      hys10   = signed'({8'd0, hys_x10});
      dmax    = {cfg.max_first_temp[15], cfg.max_first_temp} - {t1[15], t1};
      dmin    = {t2[15], t2} - {cfg.min_second_temp[15], cfg.min_second_temp};
      owl_units  = dtds_pkg::OWL_W'(cfg.change_wait_units) + dtds_pkg::OWL_W'(1);
      owl_reload = dtds_pkg::OWL_W'(owl_units * dtds_pkg::OWL_W'(dtds_pkg::WAIT_STEP));
   end

   // One tick: command, lock, calculation, output stage, countdown
   always_comb begin
      cur_in     = cur_ff;
      next_in    = next_ff;
      delta_in   = delta_ff;
      init_in    = init_ff;
      force_in   = force_ff;
      mode_in    = mode_ff;
      owl_in     = owl_ff;
      cwl_in     = cwl_ff;
      count_in   = count_ff;
      changed_in = 1'b0;

      // Command byte
      if (in_item.tick.command_valid) begin
         if (cmd == dtds_pkg::CMD_FORCE_OFF || cmd == dtds_pkg::CMD_FORCE_ON) begin
            next_in  = (cmd == dtds_pkg::CMD_FORCE_ON);
            force_in = 1'b1;
            owl_in   = '0;
         end else if (cmd <= dtds_pkg::CMD_MANUAL_MAX && !mode_ff) begin
            next_in = (cmd != dtds_pkg::CMD_MANUAL_OFF);
         end
      end

      // Channel lock
      if (cfg.channel_locked) begin
         force_in = 1'b1;
         next_in  = err_on;
         if (cur_ff != err_on) begin
            owl_in = '0;
         end
      end

      // Delta calculation
      if (force_in || in_item.tick.inhibit) begin
         mode_in = 1'b0;
      end else if (cwl_ff != '0) begin
         mode_in = mode_ff;
      end else begin
         cwl_in = cfg.calc_interval_ticks;
         priority if (t1 == NEVER_SEEN_TEMP || t2 == NEVER_SEEN_TEMP) begin
            mode_in = 1'b0;
         end else if (t1 <= SENSOR_FAULT_TEMP || t2 <= SENSOR_FAULT_TEMP) begin
            next_in = err_on;
            mode_in = 1'b0;
         end else begin
            delta_in = in_item.delta;
            mode_in  = 1'b1;
            if (t1 >= cfg.max_first_temp || t2 < cfg.min_second_temp) begin
               next_in = 1'b0;
            end else if (d17 > thr17) begin
               if ((d17 - hys17) >= thr17) begin
                  next_in = 1'b1;
                  // Start delay near the limits
                  if (!cur_ff) begin
                     if (!cfg.option_bits[dtds_pkg::OPT_NO_DELAY_MAX] &&
                         !dmax[16] && dmax < hys10) begin
                        next_in = 1'b0;
                     end
                     if (!cfg.option_bits[dtds_pkg::OPT_NO_DELAY_MIN] &&
                         !dmin[16] && dmin < hys10) begin
                        next_in = 1'b0;
                     end
                  end
               end
            end else if ((d17 + hoff17) <= thr17) begin
               next_in = 1'b0;
            end
         end
      end

      // Output stage
      if (owl_in == '0) begin
         if (cur_ff != next_in || !init_ff) begin
            count_in   = count_ff + dtds_pkg::COUNT_W'(1);
            cur_in     = next_in;
            changed_in = 1'b1;
         end
         force_in = 1'b0;
         init_in  = 1'b1;
         owl_in   = owl_reload;
      end

      // Saturating countdown
      if (owl_in != '0) begin
         owl_in = owl_in - dtds_pkg::OWL_W'(1);
      end
      if (cwl_in != '0) begin
         cwl_in = cwl_in - dtds_pkg::INTERVAL_W'(1);
      end
   end

   // Display of the stored delta
   always_comb begin
      range_in = ~delta_in[15] && (delta_in < 16'sd255);
      disp_in  = range_in ? delta_in[dtds_pkg::DISP_W-1:0] : dtds_pkg::DISPLAY_OUT;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= 1'b0;
         next_ff      <= 1'b0;
         delta_ff     <= dtds_pkg::DELTA_RESET;
         init_ff      <= 1'b0;
         force_ff     <= 1'b0;
         mode_ff      <= 1'b0;
         owl_ff       <= dtds_pkg::OWL_RESET;
         cwl_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
         if (adv) begin
            cur_ff   <= cur_in;
            next_ff  <= next_in;
            delta_ff <= delta_in;
            init_ff  <= init_in;
            force_ff <= force_in;
            mode_ff  <= mode_in;
            owl_ff   <= owl_in;
            cwl_ff   <= cwl_in;
            count_ff <= count_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (adv) begin
         pin_ff       <= cur_in ^ ~cfg.option_bits[dtds_pkg::OPT_NOT_INVERTED];
         on_ff        <= cur_in;
         mode_out_ff  <= mode_in;
         disp_ff      <= disp_in;
         range_ff     <= range_in;
         changed_ff   <= changed_in;
         count_out_ff <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pin_level      = pin_ff;
   assign rsp_output_on      = on_ff;
   assign rsp_mode_active    = mode_out_ff;
   assign rsp_delta_display  = disp_ff;
   assign rsp_delta_in_range = range_ff;
   assign rsp_state_changed  = changed_ff;
   assign rsp_press_count    = count_out_ff;

   // A committed change advances the change counter by exactly one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (adv && changed_in) |=> (count_ff == $past(count_ff) + dtds_pkg::COUNT_W'(1)))
      else $error("change count did not step on a state change");

   // Without a transaction the output state and counter hold
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(count_ff) && $stable(cur_ff) && $stable(owl_ff)))
      else $error("state moved without a transaction");

   // A shown result reflects the present output state
   a_on_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (on_ff == cur_ff))
      else $error("result output_on differs from output state");

   // The counter only changes when a state change is reported
   a_count_only_on_change: assert property (@(posedge clock) disable iff (reset)
      (adv && !changed_in) |=> $stable(count_ff))
      else $error("change count moved without a state change");

endmodule
